>>> rtl/balist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list package
// Shared sizes, request and status codes for the bounded array list store.
// ----------------------------------------------------------------------------
package balist_pkg;

  localparam int MaxEntries = 16;
  localparam int AddrW      = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int WordW      = 32;
  localparam int CapW       = 5;
  localparam int PolW       = 2;
  localparam int InW        = 40;
  localparam int OutW       = 48;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_APPEND = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_SEARCH = 3'd5,
    REQ_SORTED = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  localparam logic [PolW-1:0] POL_PLAIN     = 2'd0;
  localparam logic [PolW-1:0] POL_TRANSPOSE = 2'd1;
  localparam logic [PolW-1:0] POL_FRONT     = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_POLICY   = 1'b1;

  localparam logic [CapW-1:0] CapReset = 5'd10;

endpackage
`default_nettype wire

>>> rtl/bounded_array_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list store
// A bounded list of signed words in one synchronous memory, with read, write,
// append, insert, remove, sorted insert and search with optional reordering.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         request: req_type, position, word
//  m_axis    out        result: status, read_word, hit_position, entry_count
//  cfg       in         register writes: capacity_limit, search_policy
//
// Write, append and refused requests need no memory read; a read makes one.
// Insert moves the entries from the end down to the position up by one, then
// writes the word. Sorted insert moves up the entries, from the end, that are
// greater than the word, then writes it. Remove moves the later entries down.
// Search reads from the front to a hit or the end; a hit may swap forward.
// Each cycle makes at most one read and one write of the entry memory.
// After reset the list is empty; the memory needs no clearing.
// A result waiting on m_axis does not stop the next request being taken.
// ----------------------------------------------------------------------------
module bounded_array_list_store (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // req_type[2:0], position[7:3], word[39:8]
  input  wire  [balist_pkg::InW-1:0]      s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // status[1:0], read_word[33:2], hit_position[37:34], entry_count[42:38]
  output logic [balist_pkg::OutW-1:0]     m_axis_tdata,
  input  wire                             cfg_we_i,
  input  wire                             cfg_index_i,
  input  wire  [balist_pkg::CapW-1:0]     cfg_data_i
);
  import balist_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP    = 3'd1;
  localparam logic [2:0] S_DN    = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_SWAPA = 3'd4;
  localparam logic [2:0] S_SWAPB = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CapW-1:0]  cap_q;
  logic [PolW-1:0]  policy_q;
  logic             more_q, more_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;

  req_e             req_q, req_d;
  status_e          status_q, status_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [WordW-1:0] word_q, word_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [AddrW-1:0] lim_q, lim_d;
  logic [AddrW-1:0] paddr_q, paddr_d;
  logic [AddrW-1:0] fill_q, fill_d;
  logic [AddrW-1:0] hit_q, hit_d;
  logic [AddrW-1:0] swap_addr_q, swap_addr_d;
  logic [WordW-1:0] swap_data_q, swap_data_d;
  logic [WordW-1:0] prev_q, prev_d;
  logic [WordW-1:0] first_q, first_d;
  logic [WordW-1:0] rword_q, rword_d;
  logic [OutW-1:0]  out_data_q, out_data_d;

  logic [WordW-1:0] entry_mem [MaxEntries];
  logic [WordW-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata;

  logic [2:0]       in_req;
  logic [CntW-1:0]  in_pos;
  logic [WordW-1:0] in_word;
  logic [CntW-1:0]  cap_eff;
  logic             full;
  logic             accept;
  logic             cont;
  logic [AddrW-1:0] last_idx;

  assign in_req   = s_axis_tdata[2:0];
  assign in_pos   = s_axis_tdata[7:3];
  assign in_word  = s_axis_tdata[39:8];
  assign cap_eff  = (cap_q > CntW'(MaxEntries)) ? CntW'(MaxEntries) : cap_q;
  assign full     = count_q >= cap_eff;
  assign last_idx = AddrW'(count_q - CntW'(1));

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign cont = (req_q == REQ_SORTED) ? ($signed(rdata_q) > $signed(word_q)) : 1'b1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    more_d      = more_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    status_d    = status_q;
    pos_d       = pos_q;
    word_d      = word_q;
    cur_d       = cur_q;
    lim_d       = lim_q;
    paddr_d     = paddr_q;
    fill_d      = fill_q;
    hit_d       = hit_q;
    swap_addr_d = swap_addr_q;
    swap_data_d = swap_data_q;
    prev_d      = prev_q;
    first_d     = first_q;
    rword_d     = rword_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = word_q;
    mem_re      = 1'b0;
    mem_raddr   = cur_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d    = req_e'(in_req);
          word_d   = in_word;
          pos_d    = in_pos[AddrW-1:0];
          status_d = ST_OK;
          rword_d  = '0;
          hit_d    = '0;
          more_d   = 1'b1;
          pend_d   = 1'b0;
          state_d  = S_DONE;
          case (in_req)
            REQ_READ, REQ_REMOVE: begin
              if (in_pos < count_q) begin
                cur_d   = in_pos[AddrW-1:0];
                lim_d   = (in_req == REQ_READ) ? in_pos[AddrW-1:0] : last_idx;
                state_d = S_DN;
              end else begin
                status_d = ST_RANGE;
              end
            end
            REQ_WRITE: begin
              if (in_pos < count_q) begin
                mem_we    = 1'b1;
                mem_waddr = in_pos[AddrW-1:0];
                mem_wdata = in_word;
              end else begin
                status_d = ST_RANGE;
              end
            end
            REQ_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AddrW-1:0];
                mem_wdata = in_word;
                count_d   = count_q + CntW'(1);
              end
            end
            REQ_INSERT: begin
              if (in_pos > count_q) begin
                status_d = ST_RANGE;
              end else if (full) begin
                status_d = ST_FULL;
              end else if (in_pos == count_q) begin
                fill_d  = in_pos[AddrW-1:0];
                state_d = S_FILL;
              end else begin
                cur_d   = last_idx;
                lim_d   = in_pos[AddrW-1:0];
                state_d = S_UP;
              end
            end
            REQ_SEARCH: begin
              status_d = ST_NOTFOUND;
              if (count_q != '0) begin
                cur_d   = '0;
                lim_d   = last_idx;
                state_d = S_DN;
              end
            end
            REQ_SORTED: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (count_q == '0) begin
                fill_d  = '0;
                state_d = S_FILL;
              end else begin
                cur_d   = last_idx;
                lim_d   = '0;
                state_d = S_UP;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end

      S_UP: begin
        mem_re  = more_q;
        pend_d  = more_q;
        paddr_d = cur_q;
        if (more_q) begin
          if (cur_q == lim_q) begin
            more_d = 1'b0;
          end else begin
            cur_d = cur_q - AddrW'(1);
          end
        end
        if (pend_q) begin
          if (cont) begin
            mem_we    = 1'b1;
            mem_waddr = paddr_q + AddrW'(1);
            mem_wdata = rdata_q;
            if (paddr_q == lim_q) begin
              fill_d  = lim_q;
              state_d = S_FILL;
            end
          end else begin
            fill_d  = paddr_q + AddrW'(1);
            state_d = S_FILL;
          end
        end
      end

      S_DN: begin
        mem_re  = more_q;
        pend_d  = more_q;
        paddr_d = cur_q;
        if (more_q) begin
          if (cur_q == lim_q) begin
            more_d = 1'b0;
          end else begin
            cur_d = cur_q + AddrW'(1);
          end
        end
        if (pend_q) begin
          case (req_q)
            REQ_READ: begin
              rword_d = rdata_q;
              state_d = S_DONE;
            end
            REQ_REMOVE: begin
              if (paddr_q == pos_q) begin
                rword_d = rdata_q;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = paddr_q - AddrW'(1);
                mem_wdata = rdata_q;
              end
              if (paddr_q == lim_q) begin
                count_d = count_q - CntW'(1);
                state_d = S_DONE;
              end
            end
            REQ_SEARCH: begin
              prev_d = rdata_q;
              if (paddr_q == '0) begin
                first_d = rdata_q;
              end
              if (rdata_q == word_q) begin
                status_d = ST_OK;
                hit_d    = paddr_q;
                if ((policy_q == POL_TRANSPOSE || policy_q == POL_FRONT) &&
                    paddr_q != '0) begin
                  swap_addr_d = (policy_q == POL_TRANSPOSE) ? paddr_q - AddrW'(1) : '0;
                  swap_data_d = (policy_q == POL_TRANSPOSE) ? prev_q : first_q;
                  state_d     = S_SWAPA;
                end else begin
                  state_d = S_DONE;
                end
              end else if (paddr_q == lim_q) begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_q;
        mem_wdata = word_q;
        count_d   = count_q + CntW'(1);
        state_d   = S_DONE;
      end

      S_SWAPA: begin
        mem_we    = 1'b1;
        mem_waddr = hit_q;
        mem_wdata = swap_data_q;
        state_d   = S_SWAPB;
      end

      S_SWAPB: begin
        mem_we    = 1'b1;
        mem_waddr = swap_addr_q;
        mem_wdata = word_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {(OutW - 43)'(0), count_q, hit_q, rword_q, status_q};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CapReset;
      policy_q    <= POL_PLAIN;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CAPACITY: cap_q    <= cfg_data_i;
          REG_POLICY:   policy_q <= cfg_data_i[PolW-1:0];
          default:      cap_q    <= cap_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    status_q    <= status_d;
    pos_q       <= pos_d;
    word_q      <= word_d;
    cur_q       <= cur_d;
    lim_q       <= lim_d;
    paddr_q     <= paddr_d;
    fill_q      <= fill_d;
    hit_q       <= hit_d;
    swap_addr_q <= swap_addr_d;
    swap_data_q <= swap_data_d;
    prev_q      <= prev_d;
    first_q     <= first_d;
    rword_q     <= rword_d;
    out_data_q  <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= entry_mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire
